// ----- sv/dpcf_pkg.sv -----
// ----------------------------------------------------------------------------
// dpcf_pkg
// Shared types, codes, constants and classification helpers of the decay
// product count filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcf_pkg;

  // table sizes and counter width defaults
  localparam int DPCF_REQ_ENTRIES    = 8;
  localparam int DPCF_MOTHER_ENTRIES = 8;
  localparam int DPCF_PAIR_ENTRIES   = 8;
  localparam int DPCF_COUNT_BITS     = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // item modes as seen on the input port
  localparam logic [2:0] MODE_PARTICLE = 3'd0;
  localparam logic [2:0] MODE_REQUEST  = 3'd1;
  localparam logic [2:0] MODE_MOTHER   = 3'd2;
  localparam logic [2:0] MODE_PAIR     = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [1:0] CFG_EXCLUSIVE     = 2'd1;
  localparam logic [1:0] CFG_MATCHING      = 2'd2;
  localparam logic [1:0] CFG_EQUIV_MASK    = 2'd3;

  // equivalence mask bits
  localparam int EQ_E_MU     = 0;
  localparam int EQ_E_MU_TAU = 1;
  localparam int EQ_NU       = 2;
  localparam int EQ_UDSC     = 3;
  localparam int EQ_UDSCB    = 4;
  localparam int EQ_W_Z      = 5;

  // particle codes used by the equivalences
  localparam logic [31:0] PID_D     = 32'd1;
  localparam logic [31:0] PID_U     = 32'd2;
  localparam logic [31:0] PID_S     = 32'd3;
  localparam logic [31:0] PID_C     = 32'd4;
  localparam logic [31:0] PID_B     = 32'd5;
  localparam logic [31:0] PID_E     = 32'd11;
  localparam logic [31:0] PID_NU_E  = 32'd12;
  localparam logic [31:0] PID_MU    = 32'd13;
  localparam logic [31:0] PID_NU_MU = 32'd14;
  localparam logic [31:0] PID_TAU   = 32'd15;
  localparam logic [31:0] PID_NU_TA = 32'd16;
  localparam logic [31:0] PID_Z     = 32'd23;
  localparam logic [31:0] PID_W     = 32'd24;

  // decoded operation of a queued item
  typedef enum logic [2:0] {
    OP_PARTICLE,
    OP_REQUEST,
    OP_MOTHER,
    OP_PAIR,
    OP_CLEAR
  } op_t;

  // back part sequencer
  typedef enum logic {
    BK_RUN,
    BK_JUDGE
  } back_state_t;

  // configuration registers
  typedef struct packed {
    logic       filter_enable;
    logic       exclusive_mode;
    logic       matching_mode;
    logic [5:0] equivalence_mask;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] category;
    logic [31:0] mother_raw;
    logic [31:0] mother_mag;
    logic        last;
  } item_t;

  // magnitude of a two's complement code, most negative gives 2^31
  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // category of a code under the enabled equivalences
  function automatic logic [31:0] categorize(input logic [31:0] code,
                                             input logic [5:0]  mask);
    logic [31:0] a;
    logic        udsc;
    a    = magnitude(code);
    udsc = (a == PID_U) || (a == PID_S) || (a == PID_C);
    if (a == PID_MU && (mask[EQ_E_MU] || mask[EQ_E_MU_TAU])) return PID_E;
    if (a == PID_TAU && mask[EQ_E_MU_TAU]) return PID_E;
    if ((a == PID_NU_MU || a == PID_NU_TA) && mask[EQ_NU]) return PID_NU_E;
    if (udsc && mask[EQ_UDSC]) return PID_D;
    if ((udsc || a == PID_B) && mask[EQ_UDSCB]) return PID_D;
    if ((a == PID_Z || a == PID_W) && mask[EQ_W_Z]) return PID_Z;
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dpcf_front.sv -----
// ----------------------------------------------------------------------------
// dpcf_front
// Accepts items, decodes the mode and classifies the codes into categories
// and magnitudes before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcf_front (
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [31:0] in_particle_id,
  input  wire logic signed [31:0] in_mother_id,
  input  wire logic               in_last_in_event,
  input  wire dpcf_pkg::cfg_t     cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output dpcf_pkg::item_t         q_item
);
  import dpcf_pkg::*;

  logic accept;
  logic mode_ok;

  // accept whenever the queue has room
  assign busy   = q_full;
  assign accept = start && !busy;
  assign q_push = accept && mode_ok;

  // mode decode and classification, unknown modes are dropped here
  always_comb begin
    mode_ok           = 1'b1;
    q_item.op         = OP_PARTICLE;
    q_item.category   = categorize(in_particle_id, cfg.equivalence_mask);
    q_item.mother_raw = in_mother_id;
    q_item.mother_mag = magnitude(in_mother_id);
    q_item.last       = in_last_in_event;
    unique case (in_mode)
      MODE_PARTICLE: q_item.op = OP_PARTICLE;
      MODE_REQUEST:  q_item.op = OP_REQUEST;
      MODE_MOTHER:   q_item.op = OP_MOTHER;
      MODE_PAIR:     q_item.op = OP_PAIR;
      MODE_CLEAR:    q_item.op = OP_CLEAR;
      default:       mode_ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/dpcf_queue.sv -----
// ----------------------------------------------------------------------------
// dpcf_queue
// Small register queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire dpcf_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output dpcf_pkg::item_t      pop_item,
  output logic                 empty
);
  import dpcf_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  item_t         slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dpcf_back.sv -----
// ----------------------------------------------------------------------------
// dpcf_back
// Carries out queued items against the request, mother and pair tables,
// keeps the per-event counts and judges the event on its last particle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcf_back #(
  parameter int REQ_ENTRIES    = dpcf_pkg::DPCF_REQ_ENTRIES,
  parameter int MOTHER_ENTRIES = dpcf_pkg::DPCF_MOTHER_ENTRIES,
  parameter int PAIR_ENTRIES   = dpcf_pkg::DPCF_PAIR_ENTRIES,
  parameter int COUNT_BITS     = dpcf_pkg::DPCF_COUNT_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dpcf_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire dpcf_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic                 out_veto,
  output logic [31:0]          out_event_count,
  output logic                 out_table_overflow
);
  import dpcf_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  back_state_t state_r, state_nxt;

  // request table
  logic [31:0]           req_cat_r [REQ_ENTRIES];
  logic [31:0]           req_cat_nxt [REQ_ENTRIES];
  logic [COUNT_BITS-1:0] req_cnt_r [REQ_ENTRIES];
  logic [COUNT_BITS-1:0] req_cnt_nxt [REQ_ENTRIES];
  logic [COUNT_BITS-1:0] obs_cnt_r [REQ_ENTRIES];
  logic [COUNT_BITS-1:0] obs_cnt_nxt [REQ_ENTRIES];
  logic [REQ_ENTRIES-1:0] req_valid_r, req_valid_nxt;
  logic [REQ_ENTRIES-1:0] req_hit, req_free, req_new;

  // mother table
  logic [31:0] mot_raw_r [MOTHER_ENTRIES];
  logic [31:0] mot_raw_nxt [MOTHER_ENTRIES];
  logic [31:0] mot_mag_r [MOTHER_ENTRIES];
  logic [31:0] mot_mag_nxt [MOTHER_ENTRIES];
  logic [MOTHER_ENTRIES-1:0] mot_valid_r, mot_valid_nxt;
  logic [MOTHER_ENTRIES-1:0] mot_hit, mot_allow, mot_free, mot_new;

  // pair table
  logic [31:0] pair_m_r [PAIR_ENTRIES];
  logic [31:0] pair_m_nxt [PAIR_ENTRIES];
  logic [31:0] pair_d_r [PAIR_ENTRIES];
  logic [31:0] pair_d_nxt [PAIR_ENTRIES];
  logic [PAIR_ENTRIES-1:0] pair_valid_r, pair_valid_nxt;
  logic [PAIR_ENTRIES-1:0] pair_pend_r, pair_pend_nxt;
  logic [PAIR_ENTRIES-1:0] pair_hit, pair_free, pair_new;
  logic [PAIR_ENTRIES-1:0] pend_base;

  logic [31:0] event_cnt_r, event_cnt_nxt;
  logic        inside_r, inside_nxt;
  logic        ovf_r, ovf_nxt;
  logic        count_en;
  logic        fail_req;
  logic        fail_pair;
  logic [COUNT_BITS-1:0] obs_base;

  assign q_pop = !q_empty && (state_r == BK_RUN);

  // parallel table lookups
  always_comb begin
    for (int i = 0; i < REQ_ENTRIES; i++) begin
      req_hit[i] = req_valid_r[i] && (req_cat_r[i] == q_item.category);
    end
    for (int i = 0; i < MOTHER_ENTRIES; i++) begin
      mot_hit[i]   = mot_valid_r[i] && (mot_raw_r[i] == q_item.mother_raw);
      mot_allow[i] = mot_valid_r[i] && (mot_mag_r[i] == q_item.mother_mag);
    end
    for (int i = 0; i < PAIR_ENTRIES; i++) begin
      pair_hit[i] = pair_valid_r[i] && (pair_m_r[i] == q_item.mother_mag) &&
                    (pair_d_r[i] == q_item.category);
    end
  end

  // lowest free slot of each table, one-hot
  assign req_free  = ~req_valid_r;
  assign req_new   = req_free & (~req_free + 1'b1);
  assign mot_free  = ~mot_valid_r;
  assign mot_new   = mot_free & (~mot_free + 1'b1);
  assign pair_free = ~pair_valid_r;
  assign pair_new  = pair_free & (~pair_free + 1'b1);

  // particle counts only under an allowed mother or an empty mother table
  assign count_en = !(|mot_valid_r) || (|mot_allow);

  // execute one item
  always_comb begin
    state_nxt      = state_r;
    req_cat_nxt    = req_cat_r;
    req_cnt_nxt    = req_cnt_r;
    obs_cnt_nxt    = obs_cnt_r;
    req_valid_nxt  = req_valid_r;
    mot_raw_nxt    = mot_raw_r;
    mot_mag_nxt    = mot_mag_r;
    mot_valid_nxt  = mot_valid_r;
    pair_m_nxt     = pair_m_r;
    pair_d_nxt     = pair_d_r;
    pair_valid_nxt = pair_valid_r;
    pair_pend_nxt  = pair_pend_r;
    event_cnt_nxt  = event_cnt_r;
    inside_nxt     = inside_r;
    ovf_nxt        = ovf_r;
    obs_base       = '0;
    pend_base      = '0;
    unique case (state_r)
      BK_RUN: begin
        if (q_pop) begin
          case (q_item.op)
            OP_REQUEST: begin
              if (|req_hit) begin
                for (int i = 0; i < REQ_ENTRIES; i++) begin
                  if (req_hit[i] && req_cnt_r[i] != COUNT_MAX) begin
                    req_cnt_nxt[i] = req_cnt_r[i] + 1'b1;
                  end
                end
              end else if (|req_new) begin
                for (int i = 0; i < REQ_ENTRIES; i++) begin
                  if (req_new[i]) begin
                    req_valid_nxt[i] = 1'b1;
                    req_cat_nxt[i]   = q_item.category;
                    req_cnt_nxt[i]   = COUNT_BITS'(1);
                    obs_cnt_nxt[i]   = '0;
                  end
                end
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_MOTHER: begin
              if (!(|mot_hit)) begin
                if (|mot_new) begin
                  for (int i = 0; i < MOTHER_ENTRIES; i++) begin
                    if (mot_new[i]) begin
                      mot_valid_nxt[i] = 1'b1;
                      mot_raw_nxt[i]   = q_item.mother_raw;
                      mot_mag_nxt[i]   = q_item.mother_mag;
                    end
                  end
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            OP_PAIR: begin
              if (!(|pair_hit)) begin
                if (|pair_new) begin
                  for (int i = 0; i < PAIR_ENTRIES; i++) begin
                    if (pair_new[i]) begin
                      pair_valid_nxt[i] = 1'b1;
                      pair_m_nxt[i]     = q_item.mother_mag;
                      pair_d_nxt[i]     = q_item.category;
                      pair_pend_nxt[i]  = 1'b0;
                    end
                  end
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              req_valid_nxt  = '0;
              mot_valid_nxt  = '0;
              pair_valid_nxt = '0;
              pair_pend_nxt  = '0;
            end
            default: begin
              // particle: first enabled particle opens the event
              if (cfg.filter_enable) begin
                inside_nxt = 1'b1;
                pend_base  = inside_r ? pair_pend_r
                                      : (pair_valid_r & {PAIR_ENTRIES{cfg.matching_mode}});
                for (int i = 0; i < REQ_ENTRIES; i++) begin
                  obs_base       = inside_r ? obs_cnt_r[i] : '0;
                  obs_cnt_nxt[i] = obs_base;
                  if (count_en && req_hit[i] && obs_base != COUNT_MAX) begin
                    obs_cnt_nxt[i] = obs_base + 1'b1;
                  end
                end
                pair_pend_nxt = cfg.matching_mode ? (pend_base & ~pair_hit) : pend_base;
              end
              if (q_item.last) begin
                inside_nxt = 1'b0;
                state_nxt  = BK_JUDGE;
              end
            end
          endcase
        end
      end
      BK_JUDGE: begin
        if (cfg.filter_enable) begin
          event_cnt_nxt = event_cnt_r + 32'd1;
        end
        state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  // event judgment from the settled counts
  always_comb begin
    fail_req = 1'b0;
    for (int i = 0; i < REQ_ENTRIES; i++) begin
      if (req_valid_r[i] && ((obs_cnt_r[i] < req_cnt_r[i]) ||
          (cfg.exclusive_mode && obs_cnt_r[i] > req_cnt_r[i]))) begin
        fail_req = 1'b1;
      end
    end
    fail_pair = cfg.matching_mode && (|(pair_valid_r & pair_pend_r));
  end

  // result shown for the single judgment cycle
  assign out_valid          = (state_r == BK_JUDGE);
  assign out_veto           = out_valid && cfg.filter_enable && (fail_req || fail_pair);
  assign out_event_count    = (out_valid && cfg.filter_enable) ? event_cnt_r + 32'd1
                                                               : event_cnt_r;
  assign out_table_overflow = ovf_r;

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r  <= '0;
      mot_valid_r  <= '0;
      pair_valid_r <= '0;
      pair_pend_r  <= '0;
      event_cnt_r  <= '0;
      inside_r     <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      req_valid_r  <= req_valid_nxt;
      mot_valid_r  <= mot_valid_nxt;
      pair_valid_r <= pair_valid_nxt;
      pair_pend_r  <= pair_pend_nxt;
      event_cnt_r  <= event_cnt_nxt;
      inside_r     <= inside_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // table contents, read only where valid
  always_ff @(posedge clk) begin
    req_cat_r <= req_cat_nxt;
    req_cnt_r <= req_cnt_nxt;
    obs_cnt_r <= obs_cnt_nxt;
    mot_raw_r <= mot_raw_nxt;
    mot_mag_r <= mot_mag_nxt;
    pair_m_r  <= pair_m_nxt;
    pair_d_r  <= pair_d_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/decay_product_count_filter_top.sv -----
// ----------------------------------------------------------------------------
// decay_product_count_filter_top
// Decay product count filter: classifies particles, counts them per requested
// category and gives a veto at the end of each event.
// ----------------------------------------------------------------------------
// The last particle of an event is registered in the queue, then executed by
// the back, which moves to its judgment state and shows the result strobe.
// Throughput: the back executes one queued item per cycle while the queue is
// not empty, but pops nothing in the judgment state after a last-in-event
// item. busy is high while the two-entry queue is full. Results cannot be
// stalled by the receiver. Reset: synchronous, clears configuration, table
// valid bits, the event counter and the queue; there is no clearing pass.
`default_nettype none

module decay_product_count_filter_top #(
  parameter int REQ_ENTRIES    = dpcf_pkg::DPCF_REQ_ENTRIES,
  parameter int MOTHER_ENTRIES = dpcf_pkg::DPCF_MOTHER_ENTRIES,
  parameter int PAIR_ENTRIES   = dpcf_pkg::DPCF_PAIR_ENTRIES,
  parameter int COUNT_BITS     = dpcf_pkg::DPCF_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [5:0]         cfg_data,
  // input items
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [31:0] in_particle_id,
  input  wire logic signed [31:0] in_mother_id,
  input  wire logic               in_last_in_event,
  // results
  output logic                    out_valid,
  output logic                    out_veto,
  output logic [31:0]             out_event_count,
  output logic                    out_table_overflow
);
  import dpcf_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLE: cfg_nxt.filter_enable    = cfg_data[0];
        CFG_EXCLUSIVE:     cfg_nxt.exclusive_mode   = cfg_data[0];
        CFG_MATCHING:      cfg_nxt.matching_mode    = cfg_data[0];
        CFG_EQUIV_MASK:    cfg_nxt.equivalence_mask = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  dpcf_front u_front (
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_particle_id   (in_particle_id),
    .in_mother_id     (in_mother_id),
    .in_last_in_event (in_last_in_event),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // queue between front and back
  dpcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // back: tables, counts and judgment
  dpcf_back #(
    .REQ_ENTRIES    (REQ_ENTRIES),
    .MOTHER_ENTRIES (MOTHER_ENTRIES),
    .PAIR_ENTRIES   (PAIR_ENTRIES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_veto           (out_veto),
    .out_event_count    (out_event_count),
    .out_table_overflow (out_table_overflow)
  );

endmodule

`default_nettype wire

// ----- sv/dpcf_checker.sv -----
// ----------------------------------------------------------------------------
// dpcf_checker
// Port-level checks of the decay product count filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_veto,
  input wire logic [31:0] out_event_count,
  input wire logic        out_table_overflow
);

  // a judgment cycle is never followed by another one
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  // overflow flag is sticky
  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_table_overflow |=> out_table_overflow)
    else $error("table overflow flag dropped");

  // event count only moves on a result
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 !out_valid) |-> $stable(out_event_count))
    else $error("event count changed without a result");

  // a veto only comes from a counted event
  a_veto_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_veto) |-> (out_event_count != $past(out_event_count)))
    else $error("veto on an event that was not counted");

endmodule

bind decay_product_count_filter_top dpcf_checker u_dpcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_veto           (out_veto),
  .out_event_count    (out_event_count),
  .out_table_overflow (out_table_overflow)
);

`default_nettype wire
